// File: hdl/nc_pkg.sv
// Shared constants and types of the number classifier.
package nc_pkg;

  // Operand width of the classified value.
  localparam int DATA_WIDTH = 31;
  // Root bits of the value and of 8*value+1.
  localparam int SQ_N = (DATA_WIDTH + 1) / 2;
  localparam int SQ_M = (DATA_WIDTH + 4) / 2;
  // Width of the operand shift register and of the partial remainder.
  localparam int XW = 2 * SQ_M;
  localparam int SW = SQ_M + 3;
  // Step counter width.
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // Triangular index limit and the listed perfect numbers.
  localparam logic [31:0] TRI_LIMIT = 32'd65000;
  localparam int N_PERFECT = 5;
  localparam logic [31:0] PERFECT_LIST [N_PERFECT] = '{
    32'd6, 32'd28, 32'd496, 32'd8128, 32'd33550336
  };

  // Request to the shared shift-and-subtract unit.
  typedef struct packed {
    logic          sqrt_mode;
    logic [SW-1:0] rem;
    logic [1:0]    bits;
    logic [SW-1:0] operand;
  } step_req_t;

  // Answer of the shared unit.
  typedef struct packed {
    logic          ok;
    logic [SW-1:0] rem;
  } step_rsp_t;

endpackage

// File: hdl/nc_step.sv
// Shared shift-and-subtract step for restoring division and square root.
module nc_step (
  input  nc_pkg::step_req_t req,
  output nc_pkg::step_rsp_t rsp
);
  import nc_pkg::*;

  logic [SW-1:0] cand;
  logic [SW:0]   diff;

  // Shift in one dividend bit or two radicand bits, then try the subtraction.
  always_comb begin
    if (req.sqrt_mode) begin
      cand = {req.rem[SW-3:0], req.bits};
    end else begin
      cand = {req.rem[SW-2:0], req.bits[1]};
    end
    diff    = {1'b0, cand} - {1'b0, req.operand};
    rsp.ok  = ~diff[SW];
    rsp.rem = diff[SW] ? cand : diff[SW-1:0];
  end

endmodule

// File: hdl/number_classifier.sv
// Number classifier: prime, triangular, square, hexagonal and perfect flags.
// Each item runs a square root of the value, then of 8*value+1, then trial division by the
// divisors 2 up to floor(sqrt(value)), up to 46339 of them at 31 bits, stopping at a divisor.
// One item at a time: in_stall holds off a new one until the result goes to the output;
// a single shift-and-subtract unit does all the work, one remainder or root bit per cycle.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module number_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_prime,
  output logic        is_triangular,
  output logic        is_square,
  output logic        is_hexagonal,
  output logic        is_perfect
);
  import nc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQN  = 5'b00010,
    ST_SQM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                state;
  logic [DATA_WIDTH-1:0] n;
  logic [XW-1:0]         xsh;
  logic [SW-1:0]         rem;
  logic [SQ_M-1:0]       root;
  logic [SQ_N-1:0]       root_n;
  logic [SQ_N-1:0]       div;
  logic [CNT_W-1:0]      cnt;
  logic                  sq_flag;
  logic                  tri_flag;
  logic                  hex_flag;
  logic                  prime_flag;

  step_req_t             req;
  step_rsp_t             rsp;
  logic [SQ_M-1:0]       root_fin;
  logic [SQ_M-2:0]       tri_idx;
  logic                  tri_hit;
  logic                  perfect_hit;
  logic                  out_free;

  // Shared arithmetic unit.
  nc_step u_step (
    .req (req),
    .rsp (rsp)
  );

  // Operands for the shared unit: trial divisor, or the root so far with 01 appended.
  always_comb begin
    req.sqrt_mode = (state != ST_DIV);
    req.rem       = rem;
    req.bits      = xsh[XW-1 -: 2];
    if (state == ST_DIV) begin
      req.operand = {{(SW-SQ_N){1'b0}}, div};
    end else begin
      req.operand = {1'b0, root, 2'b01};
    end
  end

  // Root after the last square-root step, and the triangular index (s-1)/2 taken from it.
  assign root_fin = {root[SQ_M-2:0], rsp.ok};
  assign tri_idx  = root_fin[SQ_M-1:1];
  assign tri_hit  = (rsp.rem == '0)
                  && ({{(33-SQ_M){1'b0}}, tri_idx} < TRI_LIMIT);

  // Match against the listed perfect numbers.
  always_comb begin
    perfect_hit = 1'b0;
    for (int k = 0; k < N_PERFECT; k++) begin
      if ({{(32-DATA_WIDTH){1'b0}}, n} == PERFECT_LIST[k]) begin
        perfect_hit = 1'b1;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign out_free = ~out_valid | ~out_stall;

  // Sequencer: root of n, root of 8n+1, then trial division up to the root of n.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n     <= value[DATA_WIDTH-1:0];
            xsh   <= XW'(value[DATA_WIDTH-1:0]) << (XW - 2 * SQ_N);
            rem   <= '0;
            root  <= '0;
            cnt   <= CNT_W'(SQ_N - 1);
            state <= ST_SQN;
          end
        end
        ST_SQN: begin
          rem  <= rsp.rem;
          root <= {root[SQ_M-2:0], rsp.ok};
          xsh  <= xsh << 2;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            root_n  <= {root[SQ_N-2:0], rsp.ok};
            sq_flag <= (rsp.rem == '0);
            xsh     <= XW'({n, 3'b001}) << (XW - (DATA_WIDTH + 3));
            rem     <= '0;
            root    <= '0;
            cnt     <= CNT_W'(SQ_M - 1);
            state   <= ST_SQM;
          end
        end
        ST_SQM: begin
          rem  <= rsp.rem;
          root <= root_fin;
          xsh  <= xsh << 2;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            tri_flag <= tri_hit;
            hex_flag <= tri_hit & tri_idx[0];
            if (n < DATA_WIDTH'(2)) begin
              // Zero and one are not prime.
              prime_flag <= 1'b0;
              state      <= ST_FIN;
            end else if (root_n < SQ_N'(2)) begin
              // Two and three: no divisor to try.
              prime_flag <= 1'b1;
              state      <= ST_FIN;
            end else begin
              div   <= SQ_N'(2);
              xsh   <= XW'(n) << (XW - DATA_WIDTH);
              rem   <= '0;
              cnt   <= CNT_W'(DATA_WIDTH - 1);
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= rsp.rem;
          xsh <= xsh << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (rsp.rem == '0) begin
              prime_flag <= 1'b0;
              state      <= ST_FIN;
            end else if (div == root_n) begin
              prime_flag <= 1'b1;
              state      <= ST_FIN;
            end else begin
              div <= div + 1'b1;
              xsh <= XW'(n) << (XW - DATA_WIDTH);
              rem <= '0;
              cnt <= CNT_W'(DATA_WIDTH - 1);
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded from the finished flags once the previous item is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      is_prime      <= prime_flag;
      is_triangular <= tri_flag;
      is_square     <= sq_flag;
      is_hexagonal  <= hex_flag;
      is_perfect    <= perfect_hit;
    end
  end

  // An accepted item always starts with the square root of the value.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SQN))
    else $error("accepted item did not start the root pass");

  // Trial divisors stay between two and the root of the value.
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div >= SQ_N'(2) && div <= root_n))
    else $error("trial divisor out of range");

  // Hexagonal numbers are a subset of triangular numbers.
  a_hex_tri: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_hexagonal || is_triangular))
    else $error("hexagonal flag without triangular flag");

  // A square above one is never prime.
  a_prime_square: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_prime && is_square))
    else $error("value flagged both prime and square");

  // Every listed perfect number is hexagonal, composite and not a square.
  a_perfect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_perfect) |-> (is_hexagonal && !is_prime && !is_square))
    else $error("inconsistent flags for a perfect number");

endmodule

// File: verif/tb_number_classifier.sv
// Testbench for the number classifier: directed and random values checked against a predictor.
`timescale 1ns / 100ps

module tb_number_classifier;
  import nc_pkg::*;

  // Five classification flags of one value.
  typedef struct packed {
    logic prime;
    logic triangular;
    logic square;
    logic hexagonal;
    logic perfect;
  } number_flags_t;

  // One outstanding value with the flags it should produce.
  typedef struct {
    logic [DATA_WIDTH-1:0] value;
    number_flags_t         flags;
  } flag_entry_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [DATA_WIDTH-1:0] value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  is_prime;
  logic                  is_triangular;
  logic                  is_square;
  logic                  is_hexagonal;
  logic                  is_perfect;

  flag_entry_t pending_flags[$];
  int          fail_count = 0;
  bit          no_idle = 1'b0;

  number_classifier i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_prime     (is_prime),
    .is_triangular(is_triangular),
    .is_square    (is_square),
    .is_hexagonal (is_hexagonal),
    .is_perfect   (is_perfect)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is abandoned if it has not ended well beyond the slowest correct run.
  initial begin
    #(600_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Integer square root, built one bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r + (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Works out the five flags that a value should produce.
  function automatic flag_entry_t classify_value(input logic [DATA_WIDTH-1:0] v);
    flag_entry_t     e;
    longint unsigned n;
    longint unsigned d;
    longint unsigned m;
    longint unsigned s;
    longint unsigned idx;
    n = v;
    e.value = v;
    e.flags = '0;
    // Prime when no divisor exists up to the square root; 0 and 1 are not prime.
    if (n >= 2) begin
      e.flags.prime = 1'b1;
      for (d = 2; d * d <= n && e.flags.prime; d++) begin
        if (n % d == 0) e.flags.prime = 1'b0;
      end
    end
    // Triangular at index i exactly when 8n+1 is the square of 2i+1.
    m = 8 * n + 1;
    s = floor_root(m);
    if (s * s == m) begin
      idx = (s - 1) / 2;
      if (idx < TRI_LIMIT) begin
        e.flags.triangular = 1'b1;
        e.flags.hexagonal  = idx[0];
      end
    end
    s = floor_root(n);
    e.flags.square = (s * s == n);
    for (int k = 0; k < N_PERFECT; k++) begin
      if (n == PERFECT_LIST[k]) e.flags.perfect = 1'b1;
    end
    return e;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  task automatic compare_flag(input logic [DATA_WIDTH-1:0] v, input string name,
                              input logic exp_bit, input logic act_bit);
    if (act_bit !== exp_bit) begin
      note_failure($sformatf("Mismatch for value %0d: %s expected %b, got %b.",
                             v, name, exp_bit, act_bit));
    end
  endtask

  // Sends one value, with an occasional idle gap first, and records its flags.
  task automatic send_value(input logic [DATA_WIDTH-1:0] v);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    pending_flags.push_back(classify_value(v));
  endtask

  // The result side stalls in random bursts, between longer free stretches.
  initial begin : stall_bursts
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && free_left == 0) begin
        if (!no_idle && $urandom_range(0, 1) == 1) stall_left = $urandom_range(1, 15);
        else free_left = $urandom_range(1, 60);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  // Each accepted result is compared with the oldest outstanding item.
  always @(posedge clk) begin : check_results
    flag_entry_t exp_entry;
    if (!rst && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        note_failure($sformatf("Result at %0t with no item outstanding.", $time));
      end else begin
        exp_entry = pending_flags.pop_front();
        compare_flag(exp_entry.value, "is_prime", exp_entry.flags.prime, is_prime);
        compare_flag(exp_entry.value, "is_triangular", exp_entry.flags.triangular,
                     is_triangular);
        compare_flag(exp_entry.value, "is_square", exp_entry.flags.square, is_square);
        compare_flag(exp_entry.value, "is_hexagonal", exp_entry.flags.hexagonal,
                     is_hexagonal);
        compare_flag(exp_entry.value, "is_perfect", exp_entry.flags.perfect, is_perfect);
      end
    end
  end

  // Zero and one, the smallest primes, and small triangular and square values.
  task automatic test_small_values();
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(3);
    send_value(4);
    send_value(9);
    send_value(10);
    send_value(15);
    send_value(36);
    send_value(97);
  endtask

  // All five perfect numbers, plus a neighbour of one of them.
  task automatic test_perfect_numbers();
    send_value(6);
    send_value(28);
    send_value(496);
    send_value(8128);
    send_value(8129);
    send_value(33550336);
  endtask

  // Triangular sums at the last index inside the limit and at the first one outside.
  task automatic test_triangular_limit();
    send_value(31'd2112467500);
    send_value(31'd2112532500);
  endtask

  // The largest value, values around the 16-bit boundary, and 2^20.
  task automatic test_field_extremes();
    send_value(31'h7FFF_FFFF);
    send_value(65521);
    send_value(65536);
    send_value(1048576);
  endtask

  // Mostly small values, biased towards triangular and square ones; a few larger.
  task automatic test_random_values();
    int                    k;
    logic [DATA_WIDTH-1:0] v;
    for (int j = 0; j < 63; j++) begin
      k = $urandom_range(0, 9);
      if (j == 40) v = DATA_WIDTH'($urandom());
      else if (k == 0) v = DATA_WIDTH'($urandom_range(0, 22'h3F_FFFF));
      else if (k <= 2) begin
        k = $urandom_range(0, 360);
        v = DATA_WIDTH'(k * (k + 1) / 2);
      end else if (k == 3) begin
        k = $urandom_range(0, 255);
        v = DATA_WIDTH'(k * k);
      end else if (k == 4) v = DATA_WIDTH'($urandom_range(0, 15));
      else v = DATA_WIDTH'($urandom_range(0, 65535));
      send_value(v);
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int j = 0; j < 15; j++) send_value(DATA_WIDTH'($urandom_range(0, 4095)));
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_small_values();
    test_perfect_numbers();
    test_triangular_limit();
    test_field_extremes();
    test_random_values();
    test_back_to_back();
    in_valid <= 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0 && pending_flags.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
